// ===== hdl/spq_pkg.sv =====
package spq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PRIORITY_BITS = 16;
  localparam int TAG_BITS      = 32;
  localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [PRIORITY_BITS-1:0] pri_t;
  typedef logic        [TAG_BITS-1:0]      tag_t;
  typedef logic        [COUNT_BITS-1:0]    count_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef struct packed {
    logic ins;
    logic del;
  } spq_cmd_t;

endpackage

// ===== hdl/spq_cell.sv =====
module spq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::spq_cmd_t cmd,
  input  logic              head_cell,
  input  spq_pkg::pri_t     new_pri,
  input  spq_pkg::tag_t     new_tag,
  input  logic              left_ahead,
  input  logic              left_valid,
  input  spq_pkg::pri_t     left_pri,
  input  spq_pkg::tag_t     left_tag,
  input  logic              right_valid,
  input  spq_pkg::pri_t     right_pri,
  input  spq_pkg::tag_t     right_tag,
  output logic              ahead,
  output logic              valid,
  output spq_pkg::pri_t     pri,
  output spq_pkg::tag_t     tag
);
  import spq_pkg::*;

  logic valid_r, valid_nxt;
  pri_t pri_r, pri_nxt;
  tag_t tag_r, tag_nxt;

  // head keeps its place on a tie, later cells yield to an equal newcomer
  assign ahead = valid_r && (head_cell ? (pri_r >= new_pri) : (pri_r > new_pri));

  always_comb begin
    valid_nxt = valid_r;
    pri_nxt   = pri_r;
    tag_nxt   = tag_r;
    if (cmd.ins && !ahead) begin
      valid_nxt = 1'b1;
      if (left_ahead) begin
        pri_nxt = new_pri;
        tag_nxt = new_tag;
      end else begin
        valid_nxt = left_valid;
        pri_nxt   = left_pri;
        tag_nxt   = left_tag;
      end
    end else if (cmd.del) begin
      valid_nxt = right_valid;
      pri_nxt   = right_pri;
      tag_nxt   = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pri_r <= pri_nxt;
    tag_r <= tag_nxt;
  end

  assign valid = valid_r;
  assign pri   = pri_r;
  assign tag   = tag_r;

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Max-first priority queue of QUEUE_DEPTH entries held in a row of cells, one
// entry per cell in non-increasing priority order. A word is taken whenever
// start is high; busy stays low, so one insert or delete is accepted every
// cycle. The result is strobed on out_valid in the cycle after acceptance, set
// by the single registered update of the cell row, and cannot be held off by
// the receiver. Count and head fields show the queue after that operation.
module sorted_priority_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_op,
  input  spq_pkg::pri_t          in_new_priority,
  input  spq_pkg::tag_t          in_new_tag,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output spq_pkg::pri_t          out_removed_priority,
  output spq_pkg::tag_t          out_removed_tag,
  output spq_pkg::count_t        out_entry_count,
  output spq_pkg::pri_t          out_head_priority,
  output spq_pkg::tag_t          out_head_tag
);
  import spq_pkg::*;

  logic                   accept;
  logic                   full, empty;
  spq_cmd_t               cmd;
  logic [QUEUE_DEPTH-1:0] ahead_v, valid_v;
  pri_t                   pri_v [QUEUE_DEPTH];
  tag_t                   tag_v [QUEUE_DEPTH];

  logic    out_valid_r;
  status_t status_r, status_nxt;
  pri_t    rem_pri_r, rem_pri_nxt;
  tag_t    rem_tag_r, rem_tag_nxt;
  count_t  count_r, count_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = valid_v[QUEUE_DEPTH-1];
  assign empty  = !valid_v[0];

  assign cmd.ins = accept && (op_t'(in_op) == OP_INSERT) && !full;
  assign cmd.del = accept && (op_t'(in_op) == OP_DELETE) && !empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic l_ahead, l_valid, r_valid;
    pri_t l_pri, r_pri;
    tag_t l_tag, r_tag;

    if (i == 0) begin : g_first
      assign l_ahead = 1'b1;
      assign l_valid = 1'b0;
      assign l_pri   = '0;
      assign l_tag   = '0;
    end else begin : g_mid
      assign l_ahead = ahead_v[i-1];
      assign l_valid = valid_v[i-1];
      assign l_pri   = pri_v[i-1];
      assign l_tag   = tag_v[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_pri   = '0;
      assign r_tag   = '0;
    end else begin : g_inner
      assign r_valid = valid_v[i+1];
      assign r_pri   = pri_v[i+1];
      assign r_tag   = tag_v[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .head_cell  ((i == 0) ? 1'b1 : 1'b0),
      .new_pri    (in_new_priority),
      .new_tag    (in_new_tag),
      .left_ahead (l_ahead),
      .left_valid (l_valid),
      .left_pri   (l_pri),
      .left_tag   (l_tag),
      .right_valid(r_valid),
      .right_pri  (r_pri),
      .right_tag  (r_tag),
      .ahead      (ahead_v[i]),
      .valid      (valid_v[i]),
      .pri        (pri_v[i]),
      .tag        (tag_v[i])
    );
  end

  always_comb begin
    status_nxt  = STATUS_DONE;
    rem_pri_nxt = '0;
    rem_tag_nxt = '0;
    count_nxt   = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + count_t'(1);
    end else if (cmd.del) begin
      count_nxt   = count_r - count_t'(1);
      rem_pri_nxt = pri_v[0];
      rem_tag_nxt = tag_v[0];
    end else if (accept && (op_t'(in_op) == OP_INSERT)) begin
      status_nxt = STATUS_FULL;
    end else if (accept) begin
      status_nxt = STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= accept;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      rem_pri_r <= rem_pri_nxt;
      rem_tag_r <= rem_tag_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_removed_priority = rem_pri_r;
  assign out_removed_tag      = rem_tag_r;
  assign out_entry_count      = count_r;
  assign out_head_priority    = valid_v[0] ? pri_v[0] : '0;
  assign out_head_tag         = valid_v[0] ? tag_v[0] : '0;

  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_v) == 32'(count_r))
    else $error("entry count disagrees with occupied cells");

  a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_v & ~{valid_v[QUEUE_DEPTH-2:0], 1'b1}) == '0))
    else $error("occupied cells are not contiguous from the head");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    valid_v[1] |-> (pri_v[0] >= pri_v[1]))
    else $error("head cell out of order");

  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted word produced no result");

endmodule

// ===== bench/sorted_priority_queue_tb.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int RANDOM_WORDS = 1600;
  localparam int CALM_TAIL    = 200;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    status_t status;
    pri_t    removed_pri;
    tag_t    removed_tag;
    count_t  held;
    pri_t    head_pri;
    tag_t    head_tag;
  } queue_result_t;

  typedef struct {
    op_t           op;
    pri_t          pri;
    tag_t          tag;
    int            reps;
    bit            typed;
    queue_result_t want;
  } directed_row_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  logic   in_op = 1'b0;
  pri_t   in_new_priority = '0;
  tag_t   in_new_tag = '0;
  logic   out_valid;
  logic [1:0] out_status;
  pri_t   out_removed_priority;
  tag_t   out_removed_tag;
  count_t out_entry_count;
  pri_t   out_head_priority;
  tag_t   out_head_tag;

  sorted_priority_queue dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_op                (in_op),
    .in_new_priority      (in_new_priority),
    .in_new_tag           (in_new_tag),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_removed_priority (out_removed_priority),
    .out_removed_tag      (out_removed_tag),
    .out_entry_count      (out_entry_count),
    .out_head_priority    (out_head_priority),
    .out_head_tag         (out_head_tag)
  );

  always #5 clk = ~clk;

  // shadow copy of the sorted slots
  pri_t slot_pri [QUEUE_DEPTH];
  tag_t slot_tag [QUEUE_DEPTH];
  int   held_entries = 0;

  queue_result_t  pending_results[$];
  directed_row_t  directed_rows[$];

  int error_count = 0;
  int checked_count = 0;
  int cycle_count = 0;
  int insert_count = 0;
  int delete_count = 0;
  int full_refusals = 0;
  int empty_deletes = 0;
  int peak_held = 0;

  function automatic queue_result_t queue_apply(op_t op, pri_t pri, tag_t tag);
    queue_result_t r;
    int pos;
    r = '0;
    r.status = STATUS_DONE;
    if (op == OP_INSERT) begin
      if (held_entries >= QUEUE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        if (held_entries == 0 || pri > slot_pri[0]) begin
          pos = 0;
        end else begin
          pos = 1;
          while (pos < held_entries && slot_pri[pos] > pri) pos++;
        end
        for (int i = held_entries; i > pos; i--) begin
          slot_pri[i] = slot_pri[i-1];
          slot_tag[i] = slot_tag[i-1];
        end
        slot_pri[pos] = pri;
        slot_tag[pos] = tag;
        held_entries++;
      end
    end else begin
      if (held_entries == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.removed_pri = slot_pri[0];
        r.removed_tag = slot_tag[0];
        for (int i = 0; i + 1 < held_entries; i++) begin
          slot_pri[i] = slot_pri[i+1];
          slot_tag[i] = slot_tag[i+1];
        end
        held_entries--;
      end
    end
    r.held = count_t'(held_entries);
    if (held_entries > 0) begin
      r.head_pri = slot_pri[0];
      r.head_tag = slot_tag[0];
    end
    return r;
  endfunction

  task automatic add_row(input op_t op, input pri_t pri, input tag_t tag, input int reps,
                         input bit typed, input queue_result_t want);
    directed_row_t row;
    row.op = op;
    row.pri = pri;
    row.tag = tag;
    row.reps = reps;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  task automatic send_word(input op_t op, input pri_t pri, input tag_t tag,
                           input bit typed, input queue_result_t want);
    queue_result_t predicted;
    start <= 1'b1;
    in_op <= op;
    in_new_priority <= pri;
    in_new_tag <= tag;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = queue_apply(op, pri, tag);
    pending_results.push_back(typed ? want : predicted);
    if (op == OP_INSERT) insert_count++;
    else delete_count++;
    if (predicted.status == STATUS_FULL) full_refusals++;
    if (predicted.status == STATUS_EMPTY) empty_deletes++;
    if (held_entries > peak_held) peak_held = held_entries;
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    error_count++;
    if (error_count <= 10)
      $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
  endtask

  function automatic pri_t pick_priority();
    case ($urandom_range(0, 3))
      0: return pri_t'($urandom_range(0, 6) - 3);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return pri_t'($urandom);
    endcase
  endfunction

  function automatic tag_t pick_tag();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return tag_t'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("[sorted_priority_queue] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result word", 32'd0, {30'd0, out_status});
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (out_status !== want.status)
          flag_mismatch("status", 32'(want.status), 32'(out_status));
        if (out_removed_priority !== want.removed_pri)
          flag_mismatch("removed_priority", 32'(want.removed_pri), 32'(out_removed_priority));
        if (out_removed_tag !== want.removed_tag)
          flag_mismatch("removed_tag", want.removed_tag, out_removed_tag);
        if (out_entry_count !== want.held)
          flag_mismatch("entry_count", 32'(want.held), 32'(out_entry_count));
        if (out_head_priority !== want.head_pri)
          flag_mismatch("head_priority", 32'(want.head_pri), 32'(out_head_priority));
        if (out_head_tag !== want.head_tag)
          flag_mismatch("head_tag", want.head_tag, out_head_tag);
      end
    end
  end

  initial begin
    queue_result_t none;
    int insert_pct;
    bit idle_on;
    op_t op;

    none = '0;
    // typed rows: empty delete, first inserts, and the final empty delete
    add_row(OP_DELETE, 16'sh0000, 32'h0, 1, 1'b1,
            queue_result_t'{STATUS_EMPTY, 16'sh0, 32'h0, 5'd0, 16'sh0, 32'h0});
    add_row(OP_INSERT, 16'sh0000, 32'h0, 1, 1'b1,
            queue_result_t'{STATUS_DONE, 16'sh0, 32'h0, 5'd1, 16'sh0, 32'h0});
    add_row(OP_INSERT, 16'sh7fff, 32'hffffffff, 1, 1'b1,
            queue_result_t'{STATUS_DONE, 16'sh0, 32'h0, 5'd2, 16'sh7fff, 32'hffffffff});
    add_row(OP_INSERT, 16'sh8000, 32'h1, 1, 1'b0, none);
    // equal to head: lands behind the head
    add_row(OP_INSERT, 16'sh7fff, 32'h2, 1, 1'b0, none);
    // equal further down: lands ahead of the existing entry
    add_row(OP_INSERT, 16'sh0000, 32'h3, 1, 1'b0, none);
    add_row(OP_INSERT, 16'shffff, 32'h80000000, 1, 1'b0, none);
    add_row(OP_DELETE, 16'sh0000, 32'h0, 3, 1'b0, none);
    add_row(OP_INSERT, 16'shfffa, 32'h100, 13, 1'b0, none);
    add_row(OP_INSERT, 16'sh7fff, 32'haaaa5555, 1, 1'b0, none);
    add_row(OP_INSERT, 16'sh8000, 32'h5555aaaa, 1, 1'b0, none);
    add_row(OP_DELETE, 16'sh0000, 32'h0, 16, 1'b0, none);
    add_row(OP_DELETE, 16'shffff, 32'hffffffff, 1, 1'b1,
            queue_result_t'{STATUS_EMPTY, 16'sh0, 32'h0, 5'd0, 16'sh0, 32'h0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_word(directed_rows[r].op, directed_rows[r].pri + pri_t'(k),
                  directed_rows[r].tag + tag_t'(k), directed_rows[r].typed,
                  directed_rows[r].want);
      end
    end

    // drain before the random part
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    insert_pct = 50;
    idle_on = 1'b0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 4))
          0: insert_pct = 20;
          1: insert_pct = 50;
          2: insert_pct = 65;
          3: insert_pct = 80;
          default: insert_pct = 95;
        endcase
        idle_on = ($urandom_range(0, 2) != 0) && (n < RANDOM_WORDS - CALM_TAIL);
      end
      if (idle_on && $urandom_range(0, 5) == 0)
        idle_cycles($urandom_range(1, 19));
      op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_DELETE;
      send_word(op, pick_priority(), pick_tag(), 1'b0, none);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("covered %0d inserts (%0d refused as full) and %0d deletes (%0d on empty);",
             insert_count, full_refusals, delete_count, empty_deletes);
    $display("peak occupancy %0d of %0d, %0d result words compared",
             peak_held, QUEUE_DEPTH, checked_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[sorted_priority_queue] OK");
    end else begin
      $display("%0d failures", error_count);
      $display("[sorted_priority_queue] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
bench/sorted_priority_queue_tb.sv
